@@ rtl/core/ecp_pkg.sv @@
// ecp_pkg: shared types and constants of the extent compaction planner.
// No dependencies.
package ecp_pkg;
    localparam int MAX_EXTENTS = 32;
    localparam int BLOCK_BITS  = 16;
    localparam int SLOT_BITS   = $clog2(MAX_EXTENTS);
    localparam int IDX_BITS    = 5;
    localparam int EXT_BITS    = BLOCK_BITS + 1;
    localparam int PIN_BITS    = 21;
    localparam int CFG_BITS    = 16;

    localparam logic CFG_FIRST = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_MOVED   = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_NOTHING = 3'd2,
        ST_PINS    = 3'd3,
        ST_OPEN    = 3'd4,
        ST_WRITTEN = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_COVER, S_NEXT, S_PICK, S_DONE
    } state_t;

    typedef struct packed {
        logic load_write;   // store input word into table
        logic init_plan;    // start cover scan
        logic scan_clear;   // reset slot counter
        logic scan_step;    // advance slot counter
        logic cover_pass;   // evaluate coverage of current slot
        logic next_pass;    // evaluate next-start of current slot
        logic pick_pass;    // evaluate victim of current slot
        logic finish;       // form result word
        logic out_load;     // result becomes visible
    } ecp_cmd_t;

    typedef struct packed {
        logic last_slot;
        logic moved;        // a cover pass advanced the cursor
        logic no_space;     // cursor reached region end
    } ecp_stat_t;

    typedef struct packed {
        logic                  req_type;
        logic [IDX_BITS-1:0]   entry_index;
        logic                  entry_valid;
        logic [BLOCK_BITS-1:0] entry_start;
        logic [BLOCK_BITS-1:0] entry_length;
        logic                  entry_is_dir;
        logic                  entry_pinned;
        logic                  entry_open;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [BLOCK_BITS-1:0] hole_start;
        logic [BLOCK_BITS-1:0] hole_length;
        logic [IDX_BITS-1:0]   victim_slot;
        logic [BLOCK_BITS-1:0] victim_old_start;
        logic [BLOCK_BITS-1:0] victim_length;
        logic [PIN_BITS-1:0]   pinned_fit_blocks;
    } rsp_t;
endpackage

@@ rtl/core/ecp_if.sv @@
// ecp_req_if / ecp_rsp_if: valid-ready channels carrying one word each.
// Depends on ecp_pkg.
interface ecp_req_if import ecp_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ecp_rsp_if import ecp_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/extent_compaction_planner_top.sv @@
// Extent compaction planner top level: channels, output register, units.
// Depends on ecp_pkg, ecp_if, ecp_ctrl, ecp_dp.
// Write words are answered in the cycle after acceptance. A plan word runs
// 32-slot cover passes until one pass does not move the cursor (at least one;
// the scan visits one slot per cycle), then a next-start pass and a pick pass;
// a plan with no free space ends once the cursor reaches the region end.
// One word in flight at a time; the result register holds until taken.
// Reset (rst_n low, asynchronous) empties the table and zeroes the region.
module extent_compaction_planner_top import ecp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    ecp_req_if.sink            req,
    ecp_rsp_if.source          rsp
);
    ecp_cmd_t  cmd;
    ecp_stat_t stat;
    logic      valid_reg;

    // the result word stays valid until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.out_load)
            valid_reg <= 1'b1;
        else if (rsp.ready)
            valid_reg <= 1'b0;
    end
    assign rsp.valid = valid_reg;

    ecp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_is_plan (req.data.req_type),
        .in_ready   (req.ready),
        .out_busy   (valid_reg),
        .cmd        (cmd),
        .stat       (stat)
    );

    ecp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index[0]),
        .cfg_data  (cfg_data),
        .req       (req.data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp.data)
    );
endmodule

@@ rtl/core/ecp_ctrl.sv @@
// ecp_ctrl: sequencer for write and plan words.
// Depends on ecp_pkg.
module ecp_ctrl import ecp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_is_plan,
    output logic      in_ready,
    input  logic      out_busy,
    output ecp_cmd_t  cmd,
    input  ecp_stat_t stat
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = !out_busy;
                if (in_valid && !out_busy)
                begin
                    if (in_is_plan)
                    begin
                        cmd.init_plan  = 1'b1;
                        cmd.scan_clear = 1'b1;
                        state_next     = S_COVER;
                    end
                    else
                    begin
                        cmd.load_write = 1'b1;
                        cmd.out_load   = 1'b1;
                    end
                end
            end
            S_COVER:
            begin
                if (stat.no_space)
                    state_next = S_DONE;
                else
                begin
                    cmd.cover_pass = 1'b1;
                    cmd.scan_step  = 1'b1;
                    if (stat.last_slot && !stat.moved)
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_NEXT;
                    end
                    else if (stat.last_slot)
                        cmd.scan_clear = 1'b1;
                end
            end
            S_NEXT:
            begin
                cmd.next_pass = 1'b1;
                cmd.scan_step = 1'b1;
                if (stat.last_slot)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick_pass = 1'b1;
                cmd.scan_step = 1'b1;
                if (stat.last_slot)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // pick results of the last slot are settled here
                cmd.finish   = 1'b1;
                cmd.out_load = 1'b1;
                state_next   = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule

@@ rtl/core/ecp_dp.sv @@
// ecp_dp: extent table, scan cursor and victim choice.
// Depends on ecp_pkg.
module ecp_dp import ecp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data,
    input  req_t                  req,
    input  ecp_cmd_t              cmd,
    output ecp_stat_t             stat,
    output rsp_t                  rsp
);
    logic [CFG_BITS-1:0]   first_reg, count_reg;
    logic [MAX_EXTENTS-1:0] live_reg, dir_reg, pin_reg, open_reg;
    logic [BLOCK_BITS-1:0] start_reg [MAX_EXTENTS];
    logic [BLOCK_BITS-1:0] len_reg   [MAX_EXTENTS];
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [EXT_BITS-1:0]   cur_reg, nxt_reg, end_reg;
    logic                  moved_reg, found_reg, pinb_reg, openb_reg;
    logic [SLOT_BITS-1:0]  best_reg;
    logic [BLOCK_BITS-1:0] best_start_reg, best_len_reg;
    logic [PIN_BITS-1:0]   pins_reg;
    rsp_t                  rsp_reg;

    logic [EXT_BITS-1:0]   s_ext, e_ext, hl_ext, sum_ext, lim_ext;
    logic                  live_i, covers, fits, cand;

    assign lim_ext = EXT_BITS'(1) << BLOCK_BITS;
    assign sum_ext = EXT_BITS'(first_reg) + EXT_BITS'(count_reg);
    assign s_ext   = EXT_BITS'(start_reg[slot_reg]);
    assign e_ext   = s_ext + EXT_BITS'(len_reg[slot_reg]);
    assign live_i  = live_reg[slot_reg];
    assign covers  = live_i && cur_reg >= s_ext && cur_reg < e_ext;
    assign hl_ext  = nxt_reg - cur_reg;
    assign fits    = live_i && !dir_reg[slot_reg] && s_ext > cur_reg
                     && EXT_BITS'(len_reg[slot_reg]) <= hl_ext;
    assign cand    = fits && !pin_reg[slot_reg] && !open_reg[slot_reg];

    assign stat.last_slot = slot_reg == SLOT_BITS'(MAX_EXTENTS - 1);
    assign stat.moved     = moved_reg || covers;
    assign stat.no_space  = cur_reg >= end_reg;
    assign rsp            = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            count_reg <= '0;
            live_reg  <= '0;
            dir_reg   <= '0;
            pin_reg   <= '0;
            open_reg  <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_FIRST)
                first_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_COUNT)
                count_reg <= cfg_data;
            if (cmd.load_write && 32'(req.entry_index) < MAX_EXTENTS)
            begin
                live_reg[SLOT_BITS'(req.entry_index)] <= req.entry_valid;
                dir_reg[SLOT_BITS'(req.entry_index)]  <= req.entry_is_dir;
                pin_reg[SLOT_BITS'(req.entry_index)]  <= req.entry_pinned;
                open_reg[SLOT_BITS'(req.entry_index)] <= req.entry_open;
            end
            if (cmd.scan_clear)
                slot_reg <= '0;
            else if (cmd.scan_step)
                slot_reg <= slot_reg + SLOT_BITS'(1);
        end
    end

    // table payload: reset clears it as the table starts empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_EXTENTS; i++)
            begin
                start_reg[i] <= '0;
                len_reg[i]   <= '0;
            end
        end
        else if (cmd.load_write && 32'(req.entry_index) < MAX_EXTENTS)
        begin
            start_reg[SLOT_BITS'(req.entry_index)] <= req.entry_start;
            len_reg[SLOT_BITS'(req.entry_index)]   <= req.entry_length;
        end
        else if (cmd.finish && !stat.no_space && found_reg)
            start_reg[best_reg] <= cur_reg[BLOCK_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_plan)
        begin
            cur_reg   <= EXT_BITS'(first_reg);
            end_reg   <= (sum_ext < lim_ext) ? sum_ext : lim_ext;
            nxt_reg   <= (sum_ext < lim_ext) ? sum_ext : lim_ext;
            moved_reg <= 1'b0;
            found_reg <= 1'b0;
            pinb_reg  <= 1'b0;
            openb_reg <= 1'b0;
            pins_reg  <= '0;
        end
        if (cmd.cover_pass)
        begin
            if (covers)
                cur_reg <= e_ext;
            moved_reg <= stat.last_slot ? 1'b0 : (moved_reg || covers);
        end
        if (cmd.next_pass && live_i && len_reg[slot_reg] != '0
            && s_ext > cur_reg && s_ext < nxt_reg)
            nxt_reg <= s_ext;
        if (cmd.pick_pass && fits)
        begin
            if (pin_reg[slot_reg])
            begin
                pinb_reg <= 1'b1;
                pins_reg <= pins_reg + PIN_BITS'(len_reg[slot_reg]);
            end
            else if (open_reg[slot_reg])
                openb_reg <= 1'b1;
        end
        if (cmd.pick_pass && cand && (!found_reg || start_reg[slot_reg] < best_start_reg))
        begin
            found_reg      <= 1'b1;
            best_reg       <= slot_reg;
            best_start_reg <= start_reg[slot_reg];
            best_len_reg   <= len_reg[slot_reg];
        end
        if (cmd.load_write)
        begin
            rsp_reg        <= '0;
            rsp_reg.status <= ST_WRITTEN;
        end
        if (cmd.finish)
        begin
            rsp_reg <= '0;
            if (stat.no_space)
                rsp_reg.status <= ST_NOSPACE;
            else
            begin
                rsp_reg.hole_start  <= cur_reg[BLOCK_BITS-1:0];
                rsp_reg.hole_length <= hl_ext[BLOCK_BITS-1:0];
                if (found_reg)
                begin
                    rsp_reg.status            <= ST_MOVED;
                    rsp_reg.victim_slot       <= IDX_BITS'(best_reg);
                    rsp_reg.victim_old_start  <= best_start_reg;
                    rsp_reg.victim_length     <= best_len_reg;
                    rsp_reg.pinned_fit_blocks <= pins_reg;
                end
                else if (pinb_reg)
                begin
                    rsp_reg.status            <= ST_PINS;
                    rsp_reg.pinned_fit_blocks <= pins_reg;
                end
                else if (openb_reg)
                    rsp_reg.status <= ST_OPEN;
                else
                    rsp_reg.status <= ST_NOTHING;
            end
        end
    end
endmodule

@@ rtl/core/ecp_checker.sv @@
// ecp_checker: port-level assertions for the planner top level.
// Depends on ecp_pkg; bound to extent_compaction_planner_top.
module ecp_checker import ecp_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_type,
    input logic out_valid,
    input logic out_ready,
    input logic [2:0] out_status
);
    a_write_answers: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_type |=> out_valid && out_status == ST_WRITTEN)
        else $error("write word not answered");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status))
        else $error("result dropped");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status <= ST_WRITTEN)
        else $error("bad status");
endmodule

bind extent_compaction_planner_top ecp_checker u_ecp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_type    (req.data.req_type),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.data.status)
);
